// ===== src/fcca_pkg.sv =====
// shared constants and types for the cluster chain allocator
package fcca_pkg;

  localparam int DefNumClusters = 256;
  localparam logic [15:0] DefClusterBytes = 16'd512;

  localparam logic [1:0] KIND_NEW = 2'd0;
  localparam logic [1:0] KIND_FREE = 2'd1;
  localparam logic [1:0] KIND_APPEND = 2'd2;
  localparam logic [1:0] KIND_REMOVE = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_EMPTIED = 2'd2;

  typedef logic [1:0] status_t;

endpackage

// ===== src/fat_cluster_chain_allocator.sv =====
// cluster chain allocator: link table, free chain and request sequencer
// One request is in work at a time, with in_ready low until its result has been
// taken. Before the first request a clearing pass writes the reset links over
// the table. A new-file request of nonzero size first divides the size by the
// cluster size with a shift-subtract divider, then counts free clusters (up to
// need steps), then walks the free chain again (need steps); every step is one
// table read and goes through the single link table read port. Other kinds walk
// the file chain to its end, then make two table writes; an append first reads
// the free head's link once more.
module fat_cluster_chain_allocator
  import fcca_pkg::*;
#(
  parameter int NUM_CLUSTERS = DefNumClusters
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [23:0] in_file_bytes,
  input  logic [7:0]  in_chain_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [7:0]  out_cluster,
  output logic        out_free_empty,
  output logic [7:0]  out_free_head,
  output logic [7:0]  out_free_tail
);

  localparam int AW = $clog2(NUM_CLUSTERS);
  localparam int PW = AW + 1;
  localparam logic [PW-1:0] END_MARK = PW'(NUM_CLUSTERS);
  localparam logic [PW-1:0] LAST_IDX = PW'(NUM_CLUSTERS - 1);
  localparam int DW = 25;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_DIV = 4'd2;
  localparam logic [3:0] S_CNT_RD = 4'd3;
  localparam logic [3:0] S_CNT = 4'd4;
  localparam logic [3:0] S_ADV_RD = 4'd5;
  localparam logic [3:0] S_ADV = 4'd6;
  localparam logic [3:0] S_WALK_RD = 4'd7;
  localparam logic [3:0] S_WALK = 4'd8;
  localparam logic [3:0] S_WR1 = 4'd9;
  localparam logic [3:0] S_WR2 = 4'd10;
  localparam logic [3:0] S_WR3 = 4'd11;
  localparam logic [3:0] S_OUT = 4'd12;

  // link table memory
  logic [PW-1:0] mem [NUM_CLUSTERS];
  logic [PW-1:0] rdata_r;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [PW-1:0] wdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  logic [3:0]    state_r;
  logic [15:0]   cbytes_r;
  logic [1:0]    kind_r;
  logic [PW-1:0] start_r, head_r, tail_r, cur_r, prev_r, pos_r, hold_r;
  logic [PW:0]   cnt_r;
  logic [DW-1:0] need_r;
  logic [DW-1:0] rem_r;
  logic [4:0]    bit_r;
  status_t       status_r;
  logic [7:0]    cluster_r;

  // pos's link from the read port, or END_MARK when pos is out of range
  logic [PW-1:0] link;
  assign link = (pos_r < END_MARK) ? rdata_r : END_MARK;

  // divider trial subtract
  logic [DW:0]   trial;
  logic [DW-1:0] rem_sh;
  logic [15:0]   cs;
  assign cs = (cbytes_r == 16'd0) ? 16'd1 : cbytes_r;
  assign rem_sh = {rem_r[DW-2:0], need_r[DW-1]};
  assign trial = {1'b0, rem_sh} - {{(DW-15){1'b0}}, cs};

  assign in_ready = (state_r == S_IDLE);

  // memory port selection
  always_comb begin
    we = 1'b0;
    waddr = pos_r[AW-1:0];
    wdata = END_MARK;
    raddr = pos_r[AW-1:0];
    unique case (state_r)
      S_CLEAR: begin
        we = 1'b1;
        wdata = pos_r + PW'(1);
      end
      S_WR1: begin
        we = (kind_r == KIND_NEW) ? (pos_r < END_MARK)
           : (kind_r == KIND_REMOVE) ? (prev_r != END_MARK) : (cur_r < END_MARK);
        waddr = (kind_r == KIND_NEW) ? pos_r[AW-1:0]
              : (kind_r == KIND_REMOVE) ? prev_r[AW-1:0] : cur_r[AW-1:0];
        wdata = (kind_r == KIND_APPEND) ? hold_r : END_MARK;
      end
      S_WR2: begin
        we = (kind_r == KIND_APPEND) ? (hold_r < END_MARK) : (tail_r != END_MARK);
        waddr = (kind_r == KIND_APPEND) ? hold_r[AW-1:0] : tail_r[AW-1:0];
        wdata = (kind_r == KIND_APPEND) ? END_MARK
              : (kind_r == KIND_FREE) ? start_r : cur_r;
      end
      default: ;
    endcase
  end

  // request sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      pos_r <= '0;
      cbytes_r <= DefClusterBytes;
      head_r <= '0;
      tail_r <= LAST_IDX;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        cbytes_r <= cfg_wdata;
      end
      unique case (state_r)
        S_CLEAR: begin
          pos_r <= pos_r + PW'(1);
          if (pos_r == LAST_IDX) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            kind_r <= in_kind;
            start_r <= PW'(in_chain_start);
            status_r <= ST_OK;
            cluster_r <= in_chain_start;
            need_r <= {1'b0, in_file_bytes - 24'd1};
            rem_r <= '0;
            bit_r <= 5'd0;
            cur_r <= PW'(in_chain_start);
            pos_r <= PW'(in_chain_start);
            prev_r <= END_MARK;
            cnt_r <= '0;
            if (in_kind == KIND_NEW) begin
              if (in_file_bytes == 24'd0) begin
                need_r <= DW'(1);
                pos_r <= head_r;
                state_r <= S_CNT_RD;
              end else begin
                state_r <= S_DIV;
              end
            end else if (in_chain_start >= 8'(NUM_CLUSTERS > 255 ? 255 : NUM_CLUSTERS)
                         && (NUM_CLUSTERS <= 255)) begin
              state_r <= S_OUT;
            end else if (in_kind == KIND_APPEND && head_r == END_MARK) begin
              status_r <= ST_NO_SPACE;
              state_r <= S_OUT;
            end else begin
              state_r <= S_WALK_RD;
            end
          end
        end
        // restoring division, quotient shifts into need_r
        S_DIV: begin
          if (!trial[DW]) begin
            rem_r <= trial[DW-1:0];
            need_r <= {need_r[DW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            need_r <= {need_r[DW-2:0], 1'b0};
          end
          bit_r <= bit_r + 5'd1;
          if (bit_r == 5'(DW - 1)) begin
            state_r <= S_CNT_RD;
            pos_r <= head_r;
          end
        end
        S_CNT_RD: begin
          if (bit_r == 5'(DW)) begin
            need_r <= need_r + DW'(1);
            bit_r <= 5'd0;
          end
          state_r <= S_CNT;
        end
        // count free clusters up to need
        S_CNT: begin
          if (pos_r != END_MARK && DW'(cnt_r) < need_r && cnt_r < (PW+1)'(END_MARK)) begin
            cnt_r <= cnt_r + (PW+1)'(1);
            pos_r <= link;
            state_r <= S_CNT_RD;
          end else if (DW'(cnt_r) < need_r) begin
            status_r <= ST_NO_SPACE;
            cluster_r <= '0;
            state_r <= S_OUT;
          end else begin
            cluster_r <= 8'(head_r);
            pos_r <= head_r;
            cnt_r <= (PW+1)'(1);
            state_r <= S_ADV_RD;
          end
        end
        S_ADV_RD: state_r <= S_ADV;
        // advance to the new file's last cluster
        S_ADV: begin
          if (DW'(cnt_r) < need_r) begin
            cnt_r <= cnt_r + (PW+1)'(1);
            pos_r <= link;
            state_r <= S_ADV_RD;
          end else begin
            hold_r <= link;
            state_r <= S_WR1;
          end
        end
        S_WALK_RD: state_r <= S_WALK;
        // walk a file chain to its last cluster
        S_WALK: begin
          if (link != END_MARK && cnt_r < (PW+1)'(END_MARK)) begin
            prev_r <= pos_r;
            pos_r <= link;
            cur_r <= link;
            cnt_r <= cnt_r + (PW+1)'(1);
            state_r <= S_WALK_RD;
          end else begin
            state_r <= S_WR1;
            if (kind_r == KIND_APPEND) begin
              pos_r <= head_r;
              state_r <= S_WALK_RD;
              cnt_r <= (PW+1)'(END_MARK) + (PW+1)'(1);
              if (cnt_r == (PW+1)'(END_MARK) + (PW+1)'(1)) begin
                // a chain ending on the free head links back to itself first
                hold_r <= head_r;
                head_r <= (cur_r == head_r) ? head_r : link;
                state_r <= S_WR1;
                pos_r <= cur_r;
              end
            end
          end
        end
        S_WR1: begin
          if (kind_r == KIND_NEW) begin
            head_r <= hold_r;
            if (hold_r == END_MARK) begin
              tail_r <= END_MARK;
            end
            state_r <= S_OUT;
          end else begin
            if (kind_r == KIND_APPEND) begin
              cur_r <= pos_r;
            end
            state_r <= S_WR2;
          end
        end
        S_WR2: begin
          state_r <= S_OUT;
          unique case (kind_r)
            KIND_APPEND: begin
              if (head_r == END_MARK) begin
                tail_r <= END_MARK;
              end
            end
            KIND_FREE: begin
              if (tail_r == END_MARK) begin
                head_r <= start_r;
              end
              tail_r <= cur_r;
            end
            default: begin
              if (tail_r == END_MARK) begin
                head_r <= cur_r;
              end
              tail_r <= cur_r;
              if (prev_r == END_MARK) begin
                status_r <= ST_EMPTIED;
              end
            end
          endcase
        end
        S_OUT: begin
          out_valid <= 1'b1;
          out_status <= status_r;
          out_cluster <= cluster_r;
          out_free_empty <= (head_r == END_MARK);
          out_free_head <= (head_r == END_MARK) ? 8'd0 : 8'(head_r);
          out_free_tail <= (head_r == END_MARK) ? 8'd0 : 8'(tail_r);
          state_r <= S_WR3;
        end
        S_WR3: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
